@@ rtl/core/ltp_pkg.sv @@
// Shared types and constants of the length-prefixed token parser.
`default_nettype none
package ltp_pkg;

	localparam int unsigned NUM_W = 24;
	localparam logic [NUM_W-1:0] NUM_MAX = {NUM_W{1'b1}};

	localparam logic [7:0] CHR_ZERO  = 8'h30;
	localparam logic [7:0] CHR_NINE  = 8'h39;
	localparam logic [7:0] CHR_SPACE = 8'h20;

	localparam int unsigned TDATA_W = 40;

	// Parser phase, one-hot.
	typedef enum logic [2:0] {
		PH_COUNT  = 3'b001,
		PH_LENGTH = 3'b010,
		PH_CHARS  = 3'b100
	} phase_t;

	// One result word.
	typedef struct packed {
		logic [7:0]       char_value;
		logic             has_char;
		logic             token_end;
		logic             list_end;
		logic [NUM_W-1:0] token_number;
		logic             digit_error;
	} item_t;

endpackage
`default_nettype wire

@@ rtl/core/ltp_digit.sv @@
// Decimal digit step: folds one number byte into the running field value.
`default_nettype none
module ltp_digit
	import ltp_pkg::*;
(
	input  wire logic [NUM_W-1:0] acc,
	input  wire logic [7:0]       byte_in,
	output logic      [NUM_W-1:0] acc_next,
	output logic                  bad
);

	logic             is_digit;
	logic             is_space;
	logic [3:0]       digit;
	logic [NUM_W+3:0] times10;

	assign is_digit = (byte_in >= CHR_ZERO) && (byte_in <= CHR_NINE);
	assign is_space = (byte_in == CHR_SPACE);
	assign digit    = is_digit ? 4'(byte_in - CHR_ZERO) : 4'd0;
	assign bad      = !is_digit && !is_space;

	// acc * 10 as two shifts and an add, plus the new digit.
	assign times10 = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + (NUM_W+4)'(digit);

	always_comb begin
		if (is_space) begin
			acc_next = acc;
		end else if (times10 > (NUM_W+4)'(NUM_MAX)) begin
			acc_next = NUM_MAX;
		end else begin
			acc_next = times10[NUM_W-1:0];
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/ltp_parse.sv @@
// Parser state machine: count and length fields, token characters, results.
`default_nettype none
module ltp_parse
	import ltp_pkg::*;
#(
	parameter int unsigned COUNT_DIGITS  = 7,
	parameter int unsigned LENGTH_DIGITS = 2
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_accept,
	input  wire logic [7:0] byte_in,
	output logic            res_valid,
	output item_t           res_item
);

	localparam int unsigned MAX_DIGITS = (COUNT_DIGITS > LENGTH_DIGITS) ?
		COUNT_DIGITS : LENGTH_DIGITS;
	localparam int unsigned DCW = $clog2(MAX_DIGITS + 1);
	localparam int unsigned CLW = $clog2(10 ** LENGTH_DIGITS);

	phase_t           ph_q, ph_d;
	logic [DCW-1:0]   cnt_q, cnt_d, cnt_inc, ndig;
	logic [NUM_W-1:0] acc_q, acc_d, acc_next;
	logic [NUM_W-1:0] tl_q, tl_d, tl_dec;
	logic [CLW-1:0]   cl_q, cl_d, cl_dec;
	logic [NUM_W-1:0] ti_q, ti_d, ti_inc;
	logic             err_q, err_d;
	logic             bad;
	logic             done;
	logic             list_last;

	ltp_digit u_digit (
		.acc      (acc_q),
		.byte_in  (byte_in),
		.acc_next (acc_next),
		.bad      (bad)
	);

	assign ndig      = (ph_q == PH_LENGTH) ? DCW'(LENGTH_DIGITS) : DCW'(COUNT_DIGITS);
	assign cnt_inc   = cnt_q + DCW'(1);
	assign done      = (cnt_inc >= ndig);
	assign tl_dec    = (tl_q != '0) ? tl_q - NUM_W'(1) : tl_q;
	assign list_last = (tl_dec == '0);
	assign ti_inc    = ti_q + NUM_W'(1);
	assign cl_dec    = (cl_q != '0) ? cl_q - CLW'(1) : cl_q;

	always_comb begin
		ph_d      = ph_q;
		cnt_d     = cnt_q;
		acc_d     = acc_q;
		tl_d      = tl_q;
		cl_d      = cl_q;
		ti_d      = ti_q;
		err_d     = err_q;
		res_valid = 1'b0;
		res_item  = '0;
		case (ph_q)
			PH_LENGTH: begin
				cnt_d = cnt_inc;
				acc_d = acc_next;
				err_d = err_q | bad;
				if (done) begin
					cnt_d = '0;
					acc_d = '0;
					if (acc_next == '0) begin
						// Empty token marker, then move on to the next token or, after the last token, back to the count field.
						res_valid             = 1'b1;
						res_item.token_end    = 1'b1;
						res_item.list_end     = list_last;
						res_item.token_number = ti_q;
						res_item.digit_error  = err_q | bad;
						tl_d                  = tl_dec;
						if (list_last) begin
							ph_d  = PH_COUNT;
							err_d = 1'b0;
							ti_d  = '0;
						end else begin
							ph_d = PH_LENGTH;
							ti_d = ti_inc;
						end
					end else begin
						cl_d = acc_next[CLW-1:0];
						ph_d = PH_CHARS;
					end
				end
			end
			PH_CHARS: begin
				res_valid             = 1'b1;
				res_item.char_value   = byte_in;
				res_item.has_char     = 1'b1;
				res_item.token_number = ti_q;
				res_item.digit_error  = err_q;
				if (cl_dec == '0) begin
					res_item.token_end = 1'b1;
					res_item.list_end  = list_last;
					cl_d               = cl_dec;
					tl_d               = tl_dec;
					if (list_last) begin
						ph_d  = PH_COUNT;
						err_d = 1'b0;
						ti_d  = '0;
					end else begin
						ph_d = PH_LENGTH;
						ti_d = ti_inc;
					end
				end else begin
					cl_d = cl_dec;
				end
			end
			default: begin
				// Reading the list count.
				ph_d  = PH_COUNT;
				cnt_d = cnt_inc;
				acc_d = acc_next;
				err_d = err_q | bad;
				if (done) begin
					cnt_d = '0;
					acc_d = '0;
					ti_d  = '0;
					if (acc_next == '0) begin
						res_valid            = 1'b1;
						res_item.list_end    = 1'b1;
						res_item.digit_error = err_q | bad;
						tl_d                 = '0;
						err_d                = 1'b0;
					end else begin
						tl_d = acc_next;
						ph_d = PH_LENGTH;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q  <= PH_COUNT;
			cnt_q <= '0;
			acc_q <= '0;
			tl_q  <= '0;
			cl_q  <= '0;
			ti_q  <= '0;
			err_q <= 1'b0;
		end else if (in_accept) begin
			ph_q  <= ph_d;
			cnt_q <= cnt_d;
			acc_q <= acc_d;
			tl_q  <= tl_d;
			cl_q  <= cl_d;
			ti_q  <= ti_d;
			err_q <= err_d;
		end
	end

	// While characters are taken, at least one is still owed.
	a_chars_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(ph_q == PH_CHARS) |-> (cl_q != '0))
		else $error("character phase with no characters left");

	// Inside a list there is always a token still to come.
	a_tokens_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(ph_q != PH_COUNT) |-> (tl_q != '0))
		else $error("token phase with no tokens left");

	// Back in the count field the list state has been cleared.
	a_list_closed: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && res_valid && res_item.list_end) |=>
		(ph_q == PH_COUNT) && (ti_q == '0) && !err_q)
		else $error("list end did not return to a clean count field");

endmodule
`default_nettype wire

@@ rtl/core/ltp_outbuf.sv @@
// Two-entry output buffer: result register plus skid register.
`default_nettype none
module ltp_outbuf
	import ltp_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire item_t push_item,
	output logic       can_push,
	output logic       out_valid,
	input  wire logic  out_ready,
	output item_t      out_item
);

	logic  main_valid_q;
	logic  skid_valid_q;
	item_t main_q;
	item_t skid_q;
	logic  pop;

	assign pop       = main_valid_q && out_ready;
	assign can_push  = !skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_item  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				main_valid_q <= push;
			end
		end else if (!main_valid_q) begin
			main_valid_q <= push;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			main_q <= skid_valid_q ? skid_q : push_item;
		end else if (!main_valid_q) begin
			main_q <= push_item;
		end else if (push) begin
			skid_q <= push_item;
		end
	end

	a_skid_behind_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> main_valid_q)
		else $error("skid entry held without a result in front");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && pop) |=> (main_valid_q && !skid_valid_q && main_q == $past(skid_q)))
		else $error("skid entry lost on drain");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && !pop) |=> skid_valid_q && $stable(skid_q))
		else $error("skid entry overwritten");

endmodule
`default_nettype wire

@@ rtl/core/decimal_length_prefixed_token_parser.sv @@
// Top level of the decimal length-prefixed token parser.
`default_nettype none
// The block parses a byte stream of token lists. Each list opens with a
// COUNT_DIGITS-digit decimal token count; each token opens with a
// LENGTH_DIGITS-digit decimal length followed by that many raw characters.
// Every character comes out as one word with end-of-token and end-of-list
// marks; an empty token and an empty list each give one marker word with
// has_char low. In a number field a space is padding, and any other
// non-digit counts as zero and sets digit_error, which stays set for the
// rest of the list and clears after the word that closes it. Number bytes
// give no word except the last byte of a zero-valued field. The parser state
// machine and its counters update on the accepting edge of each input byte,
// and the result enters a two-entry output buffer, so one byte can be
// accepted every cycle while the output is taken.
// s_tready is a register; it drops only when both output entries are full.
module decimal_length_prefixed_token_parser
	import ltp_pkg::*;
#(
	parameter int unsigned COUNT_DIGITS  = 7,
	parameter int unsigned LENGTH_DIGITS = 2
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [7:0]         s_tdata,   // [7:0] byte_in
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	// [7:0] char_value, [8] token_end, [32:9] token_number, [33] digit_error,
	// [39:34] zero
	output logic      [TDATA_W-1:0] m_tdata,
	output logic                    m_tuser,   // [0] has_char
	output logic                    m_tlast    // list_end
);

	logic  in_accept;
	logic  res_valid;
	item_t res_item;
	item_t out_item;

	assign in_accept = s_tvalid && s_tready;

	ltp_parse #(
		.COUNT_DIGITS  (COUNT_DIGITS),
		.LENGTH_DIGITS (LENGTH_DIGITS)
	) u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_accept (in_accept),
		.byte_in   (s_tdata),
		.res_valid (res_valid),
		.res_item  (res_item)
	);

	// A result is pushed only on an accepting edge that produces one.
	ltp_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_accept && res_valid),
		.push_item (res_item),
		.can_push  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_item  (out_item)
	);

	assign m_tdata = {6'd0, out_item.digit_error, out_item.token_number,
		out_item.token_end, out_item.char_value};
	assign m_tuser = out_item.has_char;
	assign m_tlast = out_item.list_end;

	// A marker word never carries a character.
	a_marker_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata[7:0] == 8'd0))
		else $error("marker word with a character value");

	// An empty list marker is always the first token of its list.
	a_empty_list_index: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser && !m_tdata[8]) |-> (m_tlast && m_tdata[32:9] == '0))
		else $error("empty list marker malformed");

	// Closing a list always closes a token unless the list was empty.
	a_list_closes_token: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast && m_tuser) |-> m_tdata[8])
		else $error("list closed in the middle of a token");

endmodule
`default_nettype wire

@@ bench/decimal_length_prefixed_token_parser_test.sv @@
// Self-checking testbench of the decimal length-prefixed token parser.
`timescale 1ns / 100ps
module decimal_length_prefixed_token_parser_test;
	import ltp_pkg::*;

	localparam int unsigned COUNT_DIGITS  = 7;
	localparam int unsigned LENGTH_DIGITS = 2;
	localparam int unsigned RANDOM_BYTES  = 1850;
	localparam int unsigned CALM_BYTES    = 300;
	localparam int unsigned STALL_LIMIT   = 200;

	// Opening stimulus. The first list is empty. The second has a count field with
	// padding and a non-digit, so its digit_error stays set until it closes. Its
	// first token has a padded zero length (an empty token that does not end the
	// list), and its second token carries the two extreme byte values.
	localparam logic [7:0] OPENING [20] = '{
		CHR_ZERO, CHR_ZERO, CHR_ZERO, CHR_ZERO, CHR_ZERO, CHR_ZERO, CHR_ZERO,
		CHR_ZERO, CHR_SPACE, 8'h23, CHR_ZERO, CHR_ZERO, CHR_ZERO, 8'h32,
		CHR_SPACE, CHR_ZERO,
		CHR_ZERO, 8'h32, 8'h00, 8'hFF
	};

	// Tracks the parser state as bytes are accepted and holds the words that the
	// parser still owes, oldest first.
	class token_list_tracker;
		phase_t           phase;
		int unsigned      digits_taken;
		logic [NUM_W-1:0] field_value;
		logic [NUM_W-1:0] tokens_left;
		logic [NUM_W-1:0] chars_left;
		logic [NUM_W-1:0] token_index;
		logic             error_seen;
		item_t            pending_words[$];
		int unsigned      bad_words;

		function new();
			phase        = PH_COUNT;
			digits_taken = 0;
			field_value  = '0;
			tokens_left  = '0;
			chars_left   = '0;
			token_index  = '0;
			error_seen   = 1'b0;
			bad_words    = 0;
		endfunction

		// Folds one number byte into the field; returns 1 when the field is full.
		// A space leaves the value alone, any other non-digit counts as zero.
		function bit field_done(logic [7:0] b, int unsigned width);
			longint unsigned acc;
			acc = 64'(field_value);
			if (b >= CHR_ZERO && b <= CHR_NINE) begin
				acc = acc * 10 + 64'(b - CHR_ZERO);
			end else if (b != CHR_SPACE) begin
				acc = acc * 10;
				error_seen = 1'b1;
			end
			if (acc > 64'(NUM_MAX)) begin
				acc = 64'(NUM_MAX);
			end
			field_value  = acc[NUM_W-1:0];
			digits_taken = digits_taken + 1;
			return digits_taken >= width;
		endfunction

		function void owe(logic [7:0] ch, logic has, logic tend, logic lend);
			item_t w;
			w.char_value   = ch;
			w.has_char     = has;
			w.token_end    = tend;
			w.list_end     = lend;
			w.token_number = token_index;
			w.digit_error  = error_seen;
			pending_words.insert(pending_words.size(), w);
		endfunction

		// The sticky error flag and the token index clear once the list is closed.
		function void close_token();
			if (tokens_left != 0) begin
				tokens_left = tokens_left - NUM_W'(1);
			end
			token_index = token_index + NUM_W'(1);
			if (tokens_left == 0) begin
				phase       = PH_COUNT;
				error_seen  = 1'b0;
				token_index = '0;
			end else begin
				phase = PH_LENGTH;
			end
		endfunction

		function void note_byte(logic [7:0] b);
			logic [NUM_W-1:0] value;
			case (phase)
				PH_LENGTH: begin
					if (field_done(b, LENGTH_DIGITS)) begin
						value        = field_value;
						digits_taken = 0;
						field_value  = '0;
						if (value == 0) begin
							owe(8'h00, 1'b0, 1'b1, tokens_left <= 1);
							close_token();
						end else begin
							chars_left = value;
							phase      = PH_CHARS;
						end
					end
				end
				PH_CHARS: begin
					// Character bytes pass raw, digits and spaces included.
					if (chars_left != 0) begin
						chars_left = chars_left - NUM_W'(1);
					end
					if (chars_left == 0) begin
						owe(b, 1'b1, 1'b1, tokens_left <= 1);
						close_token();
					end else begin
						owe(b, 1'b1, 1'b0, 1'b0);
					end
				end
				default: begin
					phase = PH_COUNT;
					if (field_done(b, COUNT_DIGITS)) begin
						value        = field_value;
						digits_taken = 0;
						field_value  = '0;
						token_index  = '0;
						if (value == 0) begin
							// An empty list gives its marker word and waits for the next count.
							owe(8'h00, 1'b0, 1'b0, 1'b1);
							tokens_left = '0;
							error_seen  = 1'b0;
						end else begin
							tokens_left = value;
							phase       = PH_LENGTH;
						end
					end
				end
			endcase
		endfunction

		function void field_check(string name, longint unsigned want, longint unsigned got);
			if (want != got) begin
				$display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
				bad_words = bad_words + 1;
			end
		endfunction

		function void check_word(item_t got);
			item_t want;
			if (pending_words.size() == 0) begin
				$display("%0t ns: word expected none actual %p", $time, got);
				bad_words = bad_words + 1;
			end else begin
				want = pending_words.pop_front();
				field_check("char_value", want.char_value, got.char_value);
				field_check("has_char", want.has_char, got.has_char);
				field_check("token_end", want.token_end, got.token_end);
				field_check("list_end", want.list_end, got.list_end);
				field_check("token_number", want.token_number, got.token_number);
				field_check("digit_error", want.digit_error, got.digit_error);
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [7:0]         s_tdata = 8'h00;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [TDATA_W-1:0] m_tdata;
	logic               m_tuser;
	logic               m_tlast;

	token_list_tracker tracker = new();
	bit                calm = 1'b0;
	int unsigned       quiet_cycles = 0;

	decimal_length_prefixed_token_parser #(
		.COUNT_DIGITS (COUNT_DIGITS),
		.LENGTH_DIGITS(LENGTH_DIGITS)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Offers one byte and returns at the edge that accepts it. Outside the calm
	// stretch at the end, the sender sometimes drops tvalid for a burst of cycles.
	task automatic send_byte(input logic [7:0] b);
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		tracker.note_byte(b);
		if (!calm && $urandom_range(7) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
	endtask

	function automatic logic [7:0] junk_byte();
		logic [7:0] j;
		do j = 8'($urandom_range(255)); while ((j >= CHR_ZERO && j <= CHR_NINE) || j == CHR_SPACE);
		return j;
	endfunction

	// Chooses the next byte from where the parser stands, so that most of the
	// stream is well-formed lists. Counts stay small: the upper places of a count
	// are zeros, padding or non-digits (all of which keep the value at zero), and
	// only the last two places carry real digits. Length fields also take fully
	// random bytes now and then; token lengths stay at most 99 in a two-place field.
	function automatic logic [7:0] pick_byte();
		int unsigned r;
		r = $urandom_range(99);
		case (tracker.phase)
			PH_CHARS: begin
				if (r < 15) return 8'(CHR_ZERO + $urandom_range(9));
				if (r < 20) return CHR_SPACE;
				return 8'($urandom_range(255));
			end
			PH_LENGTH: begin
				if (r < 4) return 8'($urandom_range(255));
				if (r < 7) return CHR_SPACE;
				if (r < 10) return junk_byte();
				if (tracker.digits_taken == 0 && r < 85) return CHR_ZERO;
				return 8'(CHR_ZERO + $urandom_range(9));
			end
			default: begin
				if (tracker.digits_taken == COUNT_DIGITS - 1) begin
					if (r < 8) return CHR_ZERO;
					if (r < 12) return CHR_SPACE;
					if (r < 16) return junk_byte();
					return 8'(CHR_ZERO + $urandom_range(1, 5));
				end
				if (tracker.digits_taken == COUNT_DIGITS - 2 && r < 6) return CHR_ZERO + 8'd1;
				if (r < 6) return junk_byte();
				if (r < 12) return CHR_SPACE;
				return CHR_ZERO;
			end
		endcase
	endfunction

	// Receiver: ready for a random run of cycles, then stalled for a burst, except
	// in the calm stretch where it stays ready.
	initial begin : sink_ready
		forever begin
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 30)) @(posedge clk);
			if (!calm && $urandom_range(2) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end
		end
	end

	// Every accepted word is unpacked and compared with the oldest owed word.
	always @(posedge clk) begin : sink_check
		item_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.char_value   = m_tdata[7:0];
			got.token_end    = m_tdata[8];
			got.token_number = m_tdata[32:9];
			got.digit_error  = m_tdata[33];
			got.has_char     = m_tuser;
			got.list_end     = m_tlast;
			tracker.check_word(got);
		end
	end

	// Watchdog: a long run of cycles with no handshake on either side ends the run.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("decimal_length_prefixed_token_parser regression: fail");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int unsigned n;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (OPENING[i]) begin
			send_byte(OPENING[i]);
		end

		for (n = 0; n < RANDOM_BYTES; n++) begin
			// Halfway through, hold the input until the output side has drained.
			if (n == RANDOM_BYTES / 2) begin
				s_tvalid <= 1'b0;
				do @(posedge clk); while (tracker.pending_words.size() != 0);
			end
			if (n == RANDOM_BYTES - CALM_BYTES) begin
				calm = 1'b1;
			end
			send_byte(pick_byte());
		end

		s_tvalid <= 1'b0;
		while (tracker.pending_words.size() != 0) @(posedge clk);
		// Give a late stray word time to show up.
		repeat (8) @(posedge clk);
		if (tracker.bad_words == 0 && tracker.pending_words.size() == 0) begin
			$display("decimal_length_prefixed_token_parser regression: pass");
		end else begin
			$display("decimal_length_prefixed_token_parser regression: fail");
		end
		$finish;
	end

endmodule

@@ decimal_length_prefixed_token_parser.f @@
rtl/core/ltp_pkg.sv
rtl/core/ltp_digit.sv
rtl/core/ltp_parse.sv
rtl/core/ltp_outbuf.sv
rtl/core/decimal_length_prefixed_token_parser.sv
bench/decimal_length_prefixed_token_parser_test.sv
